FILE: src/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared types and constants for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

    localparam int TIME_W      = 16;
    localparam int BYTE_BITS   = 8;
    localparam int BIT_IDX_W   = $clog2(BYTE_BITS);
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BYTE_BITS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_TH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TH    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0] RST_RELOAD    = 16'hFFFE;
    localparam logic [TIME_W-1:0] RST_START_TH  = 16'd12000;
    localparam logic [TIME_W-1:0] RST_REPEAT_TH = 16'd10000;
    localparam logic [TIME_W-1:0] RST_ONE_TH    = 16'd2000;

    typedef enum logic [1:0] {
        CLS_START,
        CLS_REPEAT,
        CLS_ONE,
        CLS_ZERO
    } t_cls;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_ADDRINV,
        PH_CMD,
        PH_CMDINV,
        PH_REPEAT
    } t_phase;

    // One classified item passed from the front end to the back end.
    typedef struct packed {
        logic rd;
        t_cls cls;
    } t_item;

endpackage

FILE: src/nec_ir_front.sv
// ----------------------------------------------------------------------------
// NEC IR front end
// Holds the timing registers, forms the edge interval and classifies it.
// ----------------------------------------------------------------------------
module nec_ir_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nec_ir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nec_ir_pkg::TIME_W-1:0]     i_cfg_data,
    input  logic                              i_accept,
    input  logic                              i_mode,
    input  logic [nec_ir_pkg::TIME_W-1:0]     i_edge_time,
    output nec_ir_pkg::t_item                 o_item
);
    import nec_ir_pkg::*;

    logic [TIME_W-1:0] r_reload;
    logic [TIME_W-1:0] r_start_th;
    logic [TIME_W-1:0] r_repeat_th;
    logic [TIME_W-1:0] r_one_th;
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W-1:0] n_prev;
    logic [TIME_W-1:0] interval;
    t_cls              cls;

    // The zero threshold has no effect: anything not above the one threshold
    // decodes as a zero bit, so a write to that index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload    <= RST_RELOAD;
            r_start_th  <= RST_START_TH;
            r_repeat_th <= RST_REPEAT_TH;
            r_one_th    <= RST_ONE_TH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RELOAD:    r_reload    <= i_cfg_data;
                CFG_START_TH:  r_start_th  <= i_cfg_data;
                CFG_REPEAT_TH: r_repeat_th <= i_cfg_data;
                CFG_ONE_TH:    r_one_th    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A timer wrap is corrected against the reload value.
    always_comb begin
        if (r_prev > i_edge_time) begin
            interval = r_reload - r_prev + i_edge_time;
        end else begin
            interval = i_edge_time - r_prev;
        end
    end

    always_comb begin
        priority if (interval > r_start_th) begin
            cls = CLS_START;
        end else if (interval > r_repeat_th) begin
            cls = CLS_REPEAT;
        end else if (interval > r_one_th) begin
            cls = CLS_ONE;
        end else begin
            cls = CLS_ZERO;
        end
    end

    // A start restarts the external timer, so the next interval counts from zero.
    always_comb begin
        n_prev = r_prev;
        if (i_accept && !i_mode) begin
            n_prev = (cls == CLS_START) ? '0 : i_edge_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

    assign o_item.rd  = i_mode;
    assign o_item.cls = i_mode ? CLS_ZERO : cls;

endmodule

FILE: src/nec_ir_queue.sv
// ----------------------------------------------------------------------------
// NEC IR item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module nec_ir_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nec_ir_pkg::t_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_avail,
    output nec_ir_pkg::t_item o_item
);
    import nec_ir_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/nec_ir_back.sv
// ----------------------------------------------------------------------------
// NEC IR back end
// Frame sequencer: shifts in address and command bits, tracks the pending
// key and drives the registered result.
// ----------------------------------------------------------------------------
module nec_ir_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  nec_ir_pkg::t_item i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_key_valid,
    output logic [7:0]        o_key_code,
    output logic [7:0]        o_address_code,
    output logic              o_restart_timer,
    output logic              o_frame_done
);
    import nec_ir_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [BIT_IDX_W-1:0]   r_bit_idx, n_bit_idx;
    logic [BYTE_BITS-1:0]   r_addr, n_addr;
    logic [BYTE_BITS-1:0]   r_cmd, n_cmd;
    logic                   r_pending, n_pending;
    logic                   r_out_valid;
    logic                   r_key_valid, n_key_valid;
    logic [BYTE_BITS-1:0]   r_key_code;
    logic [BYTE_BITS-1:0]   r_addr_code;
    logic                   r_restart, n_restart;
    logic                   r_done, n_done;
    logic                   take;
    logic                   bit_edge;
    logic                   is_one;
    logic                   last_bit;

    // The output register frees up when empty or when its result is taken.
    assign take     = i_avail && (!r_out_valid || !i_out_stall);
    assign o_pop    = take;
    assign bit_edge = !i_item.rd && (i_item.cls == CLS_ONE || i_item.cls == CLS_ZERO);
    assign is_one   = (i_item.cls == CLS_ONE);
    assign last_bit = (r_bit_idx == BIT_LAST);

    // Next state of the frame sequencer.
    always_comb begin
        n_phase   = r_phase;
        n_bit_idx = r_bit_idx;
        n_addr    = r_addr;
        n_cmd     = r_cmd;
        n_pending = r_pending;
        if (take) begin
            if (i_item.rd) begin
                n_pending = 1'b0;
            end else if (i_item.cls == CLS_START) begin
                n_phase   = PH_ADDR;
                n_bit_idx = '0;
            end else if (i_item.cls == CLS_REPEAT) begin
                n_phase = PH_REPEAT;
            end else begin
                unique case (r_phase)
                    PH_ADDR: begin
                        n_addr[r_bit_idx] = is_one;
                        n_bit_idx = last_bit ? '0 : r_bit_idx + 1'b1;
                        if (last_bit) n_phase = PH_ADDRINV;
                    end
                    PH_ADDRINV: begin
                        n_bit_idx = last_bit ? '0 : r_bit_idx + 1'b1;
                        if (last_bit) n_phase = PH_CMD;
                    end
                    PH_CMD: begin
                        n_cmd[r_bit_idx] = is_one;
                        n_bit_idx = last_bit ? '0 : r_bit_idx + 1'b1;
                        if (last_bit) n_phase = PH_CMDINV;
                    end
                    PH_CMDINV: begin
                        n_bit_idx = last_bit ? '0 : r_bit_idx + 1'b1;
                        if (last_bit) begin
                            n_phase   = PH_IDLE;
                            n_pending = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result flags of the item being taken.
    always_comb begin
        n_key_valid = i_item.rd && r_pending;
        n_restart   = !i_item.rd && (i_item.cls == CLS_START);
        n_done      = bit_edge && (r_phase == PH_CMDINV) && last_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_idx   <= '0;
            r_addr      <= '0;
            r_cmd       <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_bit_idx <= n_bit_idx;
            r_addr    <= n_addr;
            r_cmd     <= n_cmd;
            r_pending <= n_pending;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key_valid <= n_key_valid;
            r_key_code  <= n_cmd;
            r_addr_code <= n_addr;
            r_restart   <= n_restart;
            r_done      <= n_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_valid     = r_key_valid;
    assign o_key_code      = r_key_code;
    assign o_address_code  = r_addr_code;
    assign o_restart_timer = r_restart;
    assign o_frame_done    = r_done;

endmodule

FILE: src/nec_ir_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder unit
// Path: an accepted item is written into the queue, then taken from it into the output register.
// Throughput: one item per cycle while the output is not stalled, set by the two-entry queue and output register.
// Reset: synchronous; configuration registers return to defaults, no frame, no key pending.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nec_ir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nec_ir_pkg::TIME_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [nec_ir_pkg::TIME_W-1:0]     i_edge_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_key_valid,
    output logic [7:0]                        o_key_code,
    output logic [7:0]                        o_address_code,
    output logic                              o_restart_timer,
    output logic                              o_frame_done
);
    import nec_ir_pkg::*;

    logic  accept;
    logic  q_full;
    logic  q_avail;
    logic  q_pop;
    t_item front_item;
    t_item back_item;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    nec_ir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_edge_time (i_edge_time),
        .o_item      (front_item)
    );

    nec_ir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_item  (back_item)
    );

    nec_ir_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (q_avail),
        .i_item          (back_item),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_key_valid     (o_key_valid),
        .o_key_code      (o_key_code),
        .o_address_code  (o_address_code),
        .o_restart_timer (o_restart_timer),
        .o_frame_done    (o_frame_done)
    );

endmodule

FILE: src/nec_ir_checker.sv
// ----------------------------------------------------------------------------
// NEC IR port checker
// Port-level assertions for the NEC infrared frame decoder unit.
// ----------------------------------------------------------------------------
module nec_ir_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_key_valid,
    input logic [7:0] o_key_code,
    input logic [7:0] o_address_code,
    input logic       o_restart_timer,
    input logic       o_frame_done
);

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A start edge never completes a frame.
    a_start_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_restart_timer && o_frame_done))
        else $error("restart and frame done in one result");

    // A key read carries no edge flags.
    a_read_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_valid) |-> (!o_restart_timer && !o_frame_done))
        else $error("key read shows edge flags");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_key_code)
            && $stable(o_address_code) && $stable(o_key_valid)))
        else $error("stalled result changed");

endmodule

bind nec_ir_frame_decoder_unit nec_ir_checker u_nec_ir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_key_valid     (o_key_valid),
    .o_key_code      (o_key_code),
    .o_address_code  (o_address_code),
    .o_restart_timer (o_restart_timer),
    .o_frame_done    (o_frame_done)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Feeds edge and key-read transactions through the valid/stall handshake,
// predicts every result with a cycle-free model of the decoder and compares
// each field. Several register settings are used, the extremes among them,
// with random sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------

class ir_key_scoreboard;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic [15:0] ZERO_TH_RESET = 16'd1000;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_code;
        logic [7:0] address_code;
        logic       restart_timer;
        logic       frame_done;
    } key_result_t;

    logic [15:0] reload_value;
    logic [15:0] start_th;
    logic [15:0] repeat_th;
    logic [15:0] one_th;
    logic [15:0] zero_th;

    logic [15:0]        prev_time;
    nec_ir_pkg::t_phase phase;
    logic [2:0]         bit_pos;
    logic [7:0]         addr_byte;
    logic [7:0]         cmd_byte;
    logic               key_pending;

    key_result_t due_results[$];
    int errors;
    int checked;
    int frames;
    int keys_read;

    function new();
        reload_value = nec_ir_pkg::RST_RELOAD;
        start_th     = nec_ir_pkg::RST_START_TH;
        repeat_th    = nec_ir_pkg::RST_REPEAT_TH;
        one_th       = nec_ir_pkg::RST_ONE_TH;
        zero_th      = ZERO_TH_RESET;
        prev_time    = '0;
        phase        = nec_ir_pkg::PH_IDLE;
        bit_pos      = '0;
        addr_byte    = '0;
        cmd_byte     = '0;
        key_pending  = 1'b0;
        errors       = 0;
        checked      = 0;
        frames       = 0;
        keys_read    = 0;
    endfunction

    function void set_reg(logic [nec_ir_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            nec_ir_pkg::CFG_RELOAD:    reload_value = val;
            nec_ir_pkg::CFG_START_TH:  start_th = val;
            nec_ir_pkg::CFG_REPEAT_TH: repeat_th = val;
            nec_ir_pkg::CFG_ONE_TH:    one_th = val;
            nec_ir_pkg::CFG_ZERO_TH:   zero_th = val;
            default: ;
        endcase
    endfunction

    // Steps the bit counter; true when the eighth bit of a byte was taken.
    function logic byte_done();
        byte_done = (bit_pos == nec_ir_pkg::BIT_LAST);
        bit_pos = bit_pos + 3'd1;
    endfunction

    function void decode_edge(logic mode, logic [15:0] stamp);
        key_result_t r;
        logic [15:0] now;
        logic [15:0] gap;
        logic        is_bit;
        logic        one;
        r = '0;
        if (mode == MODE_READ) begin
            r.key_valid = key_pending;
            if (key_pending) keys_read++;
            key_pending = 1'b0;
        end else begin
            now = stamp;
            // A timestamp below the previous one means the timer wrapped.
            if (prev_time > now) gap = reload_value - prev_time + now;
            else gap = now - prev_time;
            is_bit = 1'b0;
            one    = 1'b0;
            if (gap > start_th) begin
                phase = nec_ir_pkg::PH_ADDR;
                bit_pos = '0;
                now = '0;
                r.restart_timer = 1'b1;
            end else if (gap > repeat_th) begin
                phase = nec_ir_pkg::PH_REPEAT;
            end else begin
                is_bit = 1'b1;
                one = (gap > one_th);
            end
            if (is_bit) begin
                case (phase)
                    nec_ir_pkg::PH_ADDR: begin
                        addr_byte[bit_pos] = one;
                        if (byte_done()) phase = nec_ir_pkg::PH_ADDRINV;
                    end
                    nec_ir_pkg::PH_ADDRINV: begin
                        if (byte_done()) phase = nec_ir_pkg::PH_CMD;
                    end
                    nec_ir_pkg::PH_CMD: begin
                        cmd_byte[bit_pos] = one;
                        if (byte_done()) phase = nec_ir_pkg::PH_CMDINV;
                    end
                    nec_ir_pkg::PH_CMDINV: begin
                        if (byte_done()) begin
                            phase = nec_ir_pkg::PH_IDLE;
                            key_pending = 1'b1;
                            r.frame_done = 1'b1;
                            frames++;
                        end
                    end
                    default: ;
                endcase
            end
            prev_time = now;
        end
        r.key_code = cmd_byte;
        r.address_code = addr_byte;
        due_results.push_back(r);
    endfunction

    task report(string field, logic [15:0] want_v, logic [15:0] got_v);
        $display("ERROR: result %0d, %s: expected 0x%0h, got 0x%0h",
                 checked, field, want_v, got_v);
        errors++;
    endtask

    task check_result(logic kv, logic [7:0] kc, logic [7:0] ac, logic rt, logic fd);
        key_result_t want;
        if (due_results.size() == 0) begin
            report("result with no transaction outstanding", '0, '0);
            return;
        end
        want = due_results.pop_front();
        checked++;
        if (kv !== want.key_valid)     report("key_valid", want.key_valid, kv);
        if (kc !== want.key_code)      report("key_code", want.key_code, kc);
        if (ac !== want.address_code)  report("address_code", want.address_code, ac);
        if (rt !== want.restart_timer) report("restart_timer", want.restart_timer, rt);
        if (fd !== want.frame_done)    report("frame_done", want.frame_done, fd);
    endtask

endclass

module tb_top;
    import nec_ir_pkg::*;

    localparam logic        MODE_EDGE     = 1'b0;
    localparam logic        MODE_READ     = 1'b1;
    localparam logic [15:0] ZERO_TH_RESET = 16'd1000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 mode = 1'b0;
    logic [TIME_W-1:0]    edge_time = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 key_valid;
    logic [7:0]           key_code;
    logic [7:0]           address_code;
    logic                 restart_timer;
    logic                 frame_done;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int sent_items = 0;
    int settings = 1;

    ir_key_scoreboard key_sb = new();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nec_ir_frame_decoder_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (mode),
        .i_edge_time     (edge_time),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_key_valid     (key_valid),
        .o_key_code      (key_code),
        .o_address_code  (address_code),
        .o_restart_timer (restart_timer),
        .o_frame_done    (frame_done)
    );

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            key_sb.check_result(key_valid, key_code, address_code, restart_timer, frame_done);
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(logic m, logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        edge_time <= stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        key_sb.decode_edge(m, stamp);
        sent_items++;
        @(negedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_gap(int lo, int hi);
        if (lo > 65535) lo = 65535;
        if (hi < lo) hi = lo;
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [TIME_W-1:0] gap_for(t_cls cls);
        int st;
        int rp;
        int on;
        int lim;
        st  = key_sb.start_th;
        rp  = key_sb.repeat_th;
        on  = key_sb.one_th;
        lim = (rp < st) ? rp : st;
        case (cls)
            CLS_START:  return pick_gap(st + 1, 65535);
            CLS_REPEAT: return pick_gap(rp + 1, st);
            CLS_ONE:    return pick_gap(on + 1, lim);
            default:    return pick_gap(0, (on < lim) ? on : lim);
        endcase
    endfunction

    // Timestamp that lands the wanted interval after the last edge,
    // folding back through the reload value when the timer would overflow.
    task automatic send_edge(t_cls cls);
        logic [TIME_W:0] sum;
        logic [TIME_W-1:0] stamp;
        sum = key_sb.prev_time + gap_for(cls);
        if (sum[TIME_W]) stamp = sum[TIME_W-1:0] - key_sb.reload_value;
        else stamp = sum[TIME_W-1:0];
        send_item(MODE_EDGE, stamp);
    endtask

    // A full frame, or one broken off at bit cut_at by a new start or a repeat.
    task automatic send_frame(logic [7:0] addr, logic [7:0] cmd, int cut_at);
        logic [31:0] bits;
        bits = {~cmd, cmd, ~addr, addr};
        send_edge(CLS_START);
        for (int b = 0; b < 32; b++) begin
            if (b == cut_at) begin
                send_edge($urandom_range(1) ? CLS_START : CLS_REPEAT);
                return;
            end
            send_edge(bits[b] ? CLS_ONE : CLS_ZERO);
        end
    endtask

    task automatic run_traffic(int count);
        int stop_at;
        int pick;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_frame($urandom, $urandom,
                           ($urandom_range(7) == 0) ? $urandom_range(31) : 32);
                if ($urandom_range(9) < 7) send_item(MODE_READ, $urandom);
            end else if (pick < 63) begin
                send_edge(CLS_REPEAT);
                repeat ($urandom_range(3)) send_edge($urandom_range(1) ? CLS_ONE : CLS_ZERO);
            end else if (pick < 80) begin
                send_item(MODE_READ, $urandom);
            end else if (pick < 92) begin
                send_item(MODE_EDGE, $urandom);
            end else begin
                send_edge($urandom_range(1) ? CLS_ONE : CLS_ZERO);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        key_sb.set_reg(idx, val);
    endtask

    task automatic write_all(logic [TIME_W-1:0] rl, logic [TIME_W-1:0] st,
                             logic [TIME_W-1:0] rp, logic [TIME_W-1:0] on,
                             logic [TIME_W-1:0] zr);
        write_reg(CFG_RELOAD, rl);
        write_reg(CFG_START_TH, st);
        write_reg(CFG_REPEAT_TH, rp);
        write_reg(CFG_ONE_TH, on);
        write_reg(CFG_ZERO_TH, zr);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic write_random_setting();
        logic [TIME_W-1:0] z;
        logic [TIME_W-1:0] o;
        logic [TIME_W-1:0] r;
        logic [TIME_W-1:0] s;
        z = $urandom_range(3000);
        o = z + $urandom_range(3000, 1);
        r = o + $urandom_range(5000, 1);
        s = r + $urandom_range(5000, 1);
        write_all($urandom_range(65535, 40000), s, r, o, z);
    endtask

    task automatic wait_idle();
        while (key_sb.due_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Runs on the reset register values with the timer starting at zero.
    task automatic run_directed();
        send_item(MODE_READ, 16'hFFFF);   // nothing pending yet
        send_item(MODE_EDGE, 16'd0);      // zero interval while idle
        send_item(MODE_EDGE, 16'hFFFF);   // largest interval: start
        send_item(MODE_EDGE, 16'd1000);   // zero bit
        send_item(MODE_EDGE, 16'd3000);   // exactly at the one threshold: zero
        send_item(MODE_EDGE, 16'd5001);   // just above it: one
        send_item(MODE_EDGE, 16'd5001);   // glitch, no time elapsed: zero
        send_item(MODE_EDGE, 16'd15001);  // at the repeat threshold: still a bit
        send_item(MODE_EDGE, 16'd25002);  // just above it: repeat code
        send_item(MODE_EDGE, 16'd28000);  // bit interval ignored after a repeat
        send_item(MODE_EDGE, 16'd40000);  // at the start threshold: repeat
        send_item(MODE_EDGE, 16'd100);    // wrapped, long: start
        send_item(MODE_EDGE, 16'd12001);  // just above the start threshold
        send_item(MODE_READ, 16'd0);
        for (int t = 9000; t <= 63000; t += 9000)
            send_item(MODE_EDGE, t[15:0]);
        send_item(MODE_EDGE, 16'd2000);   // short interval across the timer wrap
        send_item(MODE_READ, 16'hA5A5);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_traffic(100);
        wait_idle();

        write_random_setting();
        send_idle_pct = 84;
        run_traffic(100);
        wait_idle();

        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        run_traffic(40);
        wait_idle();

        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_traffic(40);
        wait_idle();

        // The output is held off long enough for the input to back up.
        write_random_setting();
        recv_stall_pct = 84;
        hold_left = 150;
        run_traffic(100);
        wait_idle();

        write_all(RST_RELOAD, RST_START_TH, RST_REPEAT_TH, RST_ONE_TH, ZERO_TH_RESET);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        run_traffic(120);
        wait_idle();
        repeat (8) @(negedge clk);

        $display("Run covered %0d transactions in and %0d results checked.",
                 sent_items, key_sb.checked);
        $display("Decoded %0d complete frames, %0d keys read back, over %0d settings.",
                 key_sb.frames, key_sb.keys_read, settings);
        if (key_sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TIMEOUT: decoder stopped making progress");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
